>>> sv/ial_pkg.sv
// shared types, sizes and codes for the indexed array list
package ial_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ACT_W    = 3;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  // wide enough for a position, a cell index and the count
  localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GROUP    = 8;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;
  localparam int GSEL_W   = $clog2(GROUP);
  localparam int IN_W     = ((ACT_W + POS_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_W    = ((STAT_W + DATA_W + POS_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_READ   = 3'd2,
    ACT_FIND   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_TAP    = 2'd1,
    S_REDUCE = 2'd2,
    S_DONE   = 2'd3
  } state_e;

  typedef struct packed {
    logic                     capture;
    logic                     ins_en;
    logic                     del_en;
    logic [WIDE_W-1:0]        pos;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         used;
  } cell_ctrl_t;

endpackage

>>> sv/ial_cell.sv
// one list cell: holds an entry, shifts with its neighbors, taps and compares
module ial_cell (
  input  logic                              clk_i,
  input  ial_pkg::cell_ctrl_t               ctrl_i,
  input  logic [ial_pkg::IDX_W-1:0]         idx_i,
  input  logic signed [ial_pkg::DATA_W-1:0] left_i,
  input  logic signed [ial_pkg::DATA_W-1:0] right_i,
  output logic signed [ial_pkg::DATA_W-1:0] entry_o,
  output logic signed [ial_pkg::DATA_W-1:0] tap_o,
  output logic                              hit_o
);

  logic signed [ial_pkg::DATA_W-1:0] entry_q, entry_d;
  logic signed [ial_pkg::DATA_W-1:0] tap_q;
  logic                              hit_q;
  logic [ial_pkg::WIDE_W-1:0]        idx_w;
  logic                              at_pos;
  logic                              above;
  logic                              live;

  assign idx_w  = ial_pkg::WIDE_W'(idx_i);
  assign at_pos = (idx_w == ctrl_i.pos);
  assign above  = (idx_w > ctrl_i.pos);
  assign live   = (idx_w < ial_pkg::WIDE_W'(ctrl_i.used));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en) begin
      if (above) begin
        entry_d = left_i;
      end else if (at_pos) begin
        entry_d = ctrl_i.value;
      end
    end
    if (ctrl_i.del_en && (above || at_pos)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.capture) begin
      tap_q <= at_pos ? entry_q : '0;
      hit_q <= live && (entry_q == ctrl_i.value);
    end
  end

  assign entry_o = entry_q;
  assign tap_o   = tap_q;
  assign hit_o   = hit_q;

endmodule

>>> sv/ial_reduce.sv
// registered two-level tree: picks the tapped entry and the first match
module ial_reduce (
  input  logic                              clk_i,
  input  logic                              capture_i,
  input  logic signed [ial_pkg::DATA_W-1:0] tap_i [ial_pkg::CAPACITY],
  input  logic [ial_pkg::CAPACITY-1:0]      hit_i,
  output logic signed [ial_pkg::DATA_W-1:0] data_o,
  output logic                              any_o,
  output logic [ial_pkg::WIDE_W-1:0]        first_o
);

  logic signed [ial_pkg::DATA_W-1:0] gdata_d [ial_pkg::NGROUP];
  logic signed [ial_pkg::DATA_W-1:0] gdata_q [ial_pkg::NGROUP];
  logic [ial_pkg::GSEL_W-1:0]        gsel_d  [ial_pkg::NGROUP];
  logic [ial_pkg::GSEL_W-1:0]        gsel_q  [ial_pkg::NGROUP];
  logic [ial_pkg::NGROUP-1:0]        ghit_d, ghit_q;

  // first level: one or-tree and priority pick inside each group
  always_comb begin
    for (int g = 0; g < ial_pkg::NGROUP; g++) begin
      gdata_d[g] = '0;
      gsel_d[g]  = '0;
      ghit_d[g]  = 1'b0;
      for (int k = ial_pkg::GROUP - 1; k >= 0; k--) begin
        if (g * ial_pkg::GROUP + k < ial_pkg::CAPACITY) begin
          gdata_d[g] = gdata_d[g] | tap_i[g * ial_pkg::GROUP + k];
          if (hit_i[g * ial_pkg::GROUP + k]) begin
            ghit_d[g] = 1'b1;
            gsel_d[g] = ial_pkg::GSEL_W'(k);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      gdata_q <= gdata_d;
      gsel_q  <= gsel_d;
      ghit_q  <= ghit_d;
    end
  end

  // second level: across groups, lowest group wins
  always_comb begin
    data_o  = '0;
    first_o = '0;
    for (int g = ial_pkg::NGROUP - 1; g >= 0; g--) begin
      data_o = data_o | gdata_q[g];
      if (ghit_q[g]) begin
        first_o = ial_pkg::WIDE_W'(g * ial_pkg::GROUP) + ial_pkg::WIDE_W'(gsel_q[g]);
      end
    end
  end

  assign any_o = |ghit_q;

endmodule

>>> sv/indexed_array_list.sv
// top level of the indexed array list
// Ordered list of signed 32-bit values kept in a row of cells.
// Input channel s_axis carries one request item: insert, delete, read,
// find or clear, with a position and a value. Output channel m_axis
// carries one result item per request: status, data, found_at, count.
// After acceptance, each request passes these steps to the result register:
// the cells tap and compare their entries, a registered tree reduces the
// taps and matches, then the result is formed and the cells shift.
// One request is in progress at a time; the next one is not accepted until
// the last has formed its result, and s_axis_tready is high only while no
// request is in progress.
// A finished result waits in the output register; while the receiver
// stalls, the next request may be accepted and runs up to its last step,
// where it holds until the output register frees.
// Reset empties the list (count zero) and drops any pending result;
// entries are not cleared, only the count, so nothing stale is read.
module indexed_array_list (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // action [2:0], position [8:3], value [40:9], zero fill above
  input  logic [ial_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // status [1:0], data [33:2], found_at [39:34], count [46:40], zero fill above
  output logic [ial_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int AL = ial_pkg::ACT_W;
  localparam int PL = AL + ial_pkg::POS_W;
  localparam int VL = PL + ial_pkg::DATA_W;

  ial_pkg::state_e                   state_q, state_d;
  ial_pkg::action_e                  act_q;
  logic [ial_pkg::POS_W-1:0]         pos_q;
  logic signed [ial_pkg::DATA_W-1:0] val_q;
  logic [ial_pkg::CNT_W-1:0]         used_q, used_d;

  logic                              m_valid_q;
  ial_pkg::status_e                  status_q, status_d;
  logic signed [ial_pkg::DATA_W-1:0] data_q, data_d;
  logic [ial_pkg::POS_W-1:0]         found_q, found_d;
  logic [ial_pkg::CNT_W-1:0]         count_q;

  logic                              accept;
  logic                              out_free;
  logic                              load;
  logic                              ins_ok, del_ok;
  logic [ial_pkg::WIDE_W-1:0]        pos_w, used_w;
  ial_pkg::cell_ctrl_t               ctrl;

  logic signed [ial_pkg::DATA_W-1:0] entry_w [ial_pkg::CAPACITY];
  logic signed [ial_pkg::DATA_W-1:0] tap_w   [ial_pkg::CAPACITY];
  logic [ial_pkg::CAPACITY-1:0]      hit_w;
  logic signed [ial_pkg::DATA_W-1:0] red_data;
  logic                              red_any;
  logic [ial_pkg::WIDE_W-1:0]        red_first;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign load     = (state_q == ial_pkg::S_DONE) && out_free;
  assign pos_w    = ial_pkg::WIDE_W'(pos_q);
  assign used_w   = ial_pkg::WIDE_W'(used_q);
  assign ins_ok   = (used_q != ial_pkg::CNT_W'(ial_pkg::CAPACITY)) && (pos_w <= used_w);
  assign del_ok   = (pos_w < used_w);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ial_pkg::S_IDLE:   if (s_axis_tvalid) state_d = ial_pkg::S_TAP;
      ial_pkg::S_TAP:    state_d = ial_pkg::S_REDUCE;
      ial_pkg::S_REDUCE: state_d = ial_pkg::S_DONE;
      ial_pkg::S_DONE:   if (out_free) state_d = ial_pkg::S_IDLE;
      default:           state_d = ial_pkg::S_IDLE;
    endcase
  end

  // state outputs: handshake and cell controls
  always_comb begin
    s_axis_tready = (state_q == ial_pkg::S_IDLE);
    ctrl.capture  = (state_q == ial_pkg::S_TAP);
    ctrl.ins_en   = load && (act_q == ial_pkg::ACT_INSERT) && ins_ok;
    ctrl.del_en   = load && (act_q == ial_pkg::ACT_DELETE) && del_ok;
    ctrl.pos      = pos_w;
    ctrl.value    = val_q;
    ctrl.used     = used_q;
  end

  // result of the held request
  always_comb begin
    status_d = ial_pkg::ST_OK;
    data_d   = '0;
    found_d  = '0;
    used_d   = used_q;
    case (act_q)
      ial_pkg::ACT_INSERT: begin
        if (used_q == ial_pkg::CNT_W'(ial_pkg::CAPACITY)) begin
          status_d = ial_pkg::ST_FULL;
        end else if (!ins_ok) begin
          status_d = ial_pkg::ST_RANGE;
        end else begin
          used_d = used_q + 1'b1;
        end
      end
      ial_pkg::ACT_DELETE: begin
        if (!del_ok) begin
          status_d = ial_pkg::ST_RANGE;
        end else begin
          data_d = red_data;
          used_d = used_q - 1'b1;
        end
      end
      ial_pkg::ACT_READ: begin
        if (!del_ok) begin
          status_d = ial_pkg::ST_RANGE;
        end else begin
          data_d = red_data;
        end
      end
      ial_pkg::ACT_FIND: begin
        if (red_any) begin
          found_d = ial_pkg::POS_W'(red_first);
        end else begin
          status_d = ial_pkg::ST_MISSING;
        end
      end
      ial_pkg::ACT_CLEAR: used_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ial_pkg::S_IDLE;
      used_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        used_q    <= used_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= ial_pkg::action_e'(s_axis_tdata[AL-1:0]);
      pos_q <= s_axis_tdata[PL-1:AL];
      val_q <= s_axis_tdata[VL-1:PL];
    end
    if (load) begin
      status_q <= status_d;
      data_q   <= data_d;
      found_q  <= found_d;
      count_q  <= used_d;
    end
  end

  // row of cells, each shifting toward its neighbors
  for (genvar i = 0; i < ial_pkg::CAPACITY; i++) begin : g_cell
    logic signed [ial_pkg::DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = val_q;
    end else begin : g_mid_l
      assign left_w = entry_w[i-1];
    end
    if (i == ial_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_w[i+1];
    end
    ial_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (ial_pkg::IDX_W'(i)),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[i]),
      .tap_o   (tap_w[i]),
      .hit_o   (hit_w[i])
    );
  end

  ial_reduce u_reduce (
    .clk_i     (clk_i),
    .capture_i (state_q == ial_pkg::S_REDUCE),
    .tap_i     (tap_w),
    .hit_i     (hit_w),
    .data_o    (red_data),
    .any_o     (red_any),
    .first_o   (red_first)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = ial_pkg::OUT_W'({count_q, found_q, data_q, status_q});

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= ial_pkg::CNT_W'(ial_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ial_pkg::S_TAP))
    else $error("accepted item did not start the tap step");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_en |=> (used_q == $past(used_q) + 1'b1))
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.del_en |=> (used_q == $past(used_q) - 1'b1))
    else $error("delete did not shrink the list");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (status_q == ial_pkg::ST_FULL)) |->
      (count_q == ial_pkg::CNT_W'(ial_pkg::CAPACITY)))
    else $error("list full reported below capacity");
`endif

endmodule
